### src/dsc_pkg.sv
// ============================================================================
// Dictionary segmentation counter package
// Sizes, payload types, operation codes, state codes and the saturating adder.
// ============================================================================
package dsc_pkg;

  localparam int MAX_WORD_LEN = 8;
  localparam int DICT_DEPTH   = 512;
  localparam int COUNT_BITS   = 64;

  localparam int SYM_W   = 8;
  localparam int WORD_W  = 64;
  localparam int LEN_W   = 4;
  localparam int OP_W    = 2;
  localparam int FIELD_W = 64;

  localparam int ADDR_W = (DICT_DEPTH > 1) ? $clog2(DICT_DEPTH) : 1;
  localparam int WC_W   = $clog2(DICT_DEPTH + 1);
  localparam int SIP_W  = $clog2(MAX_WORD_LEN + 1);

  localparam logic [OP_W-1:0] OP_ADD_WORD = 2'd0;
  localparam logic [OP_W-1:0] OP_SYMBOL   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [MAX_WORD_LEN-1:0][SYM_W-1:0] sym_hist_t;
  typedef logic [MAX_WORD_LEN-1:0][COUNT_BITS-1:0] ways_hist_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] word_symbols;
    logic [LEN_W-1:0]  word_length;
    logic [SYM_W-1:0]  symbol;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] pattern_ways;
    logic               pattern_possible;
    logic [FIELD_W-1:0] running_total;
    logic               dictionary_overflow;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // Pattern context handed to the compare unit for the current symbol.
  typedef struct packed {
    sym_hist_t        hist;
    ways_hist_t       ways;
    logic [SIP_W-1:0] sip;
  } match_ctx_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

endpackage

### src/dsc_in_if.sv
// ============================================================================
// Input channel interface
// Valid/ready channel carrying one command or pattern symbol per transfer.
// ============================================================================
interface dsc_in_if;
  logic              valid;
  logic              ready;
  dsc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

### src/dsc_out_if.sv
// ============================================================================
// Result channel interface
// Valid/ready channel carrying one finished pattern result per transfer.
// ============================================================================
interface dsc_out_if;
  logic               valid;
  logic               ready;
  dsc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

### src/dsc_dict_mem.sv
// ============================================================================
// Dictionary memory
// One write port and one read port with registered read data.
// ============================================================================
module dsc_dict_mem (
  input  logic                       clk,
  input  logic                       we,
  input  logic [dsc_pkg::ADDR_W-1:0] waddr,
  input  dsc_pkg::entry_t            wdata,
  input  logic                       re,
  input  logic [dsc_pkg::ADDR_W-1:0] raddr,
  output dsc_pkg::entry_t            rdata_r
);

  dsc_pkg::entry_t mem [dsc_pkg::DICT_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### src/dsc_match_unit.sv
// ============================================================================
// Word match unit
// Checks one dictionary entry against the symbol history and registers the
// way count it contributes.
// ============================================================================
module dsc_match_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dsc_pkg::entry_t     entry,
  input  dsc_pkg::match_ctx_t ctx,
  output dsc_pkg::count_t     addend_r,
  output logic                valid_r
);

  logic [dsc_pkg::MAX_WORD_LEN:1] hit;
  dsc_pkg::count_t                addend_nxt;

  // Each candidate length is checked against fixed history taps; the stored
  // length then picks which result counts.
  always_comb begin
    addend_nxt = '0;
    for (int l = 1; l <= dsc_pkg::MAX_WORD_LEN; l++) begin
      hit[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (entry.word[dsc_pkg::SYM_W*j +: dsc_pkg::SYM_W] != ctx.hist[l-1-j]) begin
          hit[l] = 1'b0;
        end
      end
    end
    for (int l = 1; l <= dsc_pkg::MAX_WORD_LEN; l++) begin
      if (hit[l] && (entry.len == dsc_pkg::LEN_W'(l)) && (ctx.sip >= dsc_pkg::SIP_W'(l))) begin
        addend_nxt = ctx.ways[l-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    addend_r <= addend_nxt;
  end

endmodule

### src/dictionary_segmentation_counter.sv
// ============================================================================
// Dictionary segmentation counter
// Counts the ways each streamed pattern splits into dictionary words.
// ============================================================================
// Word add and clear commands are taken without leaving the idle state.
// A pattern symbol holds the input off while the dictionary is scanned:
// the single read port of the dictionary memory scans one entry per cycle.
// A result is offered in the cycle the input is ready again; while an earlier
// result still waits for its transfer, the next result holds the input off.
// Reset (rst_n low at a clock edge) empties the dictionary, the total, the
// overflow flag, the mode and the pattern state; memory contents are kept.
module dictionary_segmentation_counter (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  dsc_in_if.sink           in_chan,
  dsc_out_if.source        out_chan
);

  dsc_pkg::state_t           state_r, state_nxt;
  logic [dsc_pkg::WC_W-1:0]  wcount_r, wcount_nxt;
  logic [dsc_pkg::WC_W-1:0]  iss_r, iss_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      mode_r;
  dsc_pkg::count_t           total_r, total_nxt;
  dsc_pkg::count_t           acc_r, acc_nxt;
  dsc_pkg::sym_hist_t        hist_r, hist_nxt;
  dsc_pkg::ways_hist_t       ways_r, ways_nxt;
  logic [dsc_pkg::SIP_W-1:0] sip_r, sip_nxt;
  logic                      last_r, last_nxt;
  logic                      rd_valid_r, rd_valid_nxt;
  logic                      out_valid_r, out_valid_nxt;
  dsc_pkg::out_item_t        out_data_r, out_data_nxt;

  logic                in_xfer;
  logic                issue;
  logic                mem_we;
  dsc_pkg::entry_t     mem_wdata;
  dsc_pkg::entry_t     mem_rdata;
  dsc_pkg::match_ctx_t ctx;
  dsc_pkg::count_t     addend;
  logic                addend_valid;
  dsc_pkg::count_t     total_sum;
  logic                possible;

  assign in_chan.ready  = (state_r == dsc_pkg::ST_IDLE);
  assign in_xfer        = in_chan.valid && in_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // One entry is read per scan cycle while entries remain.
  assign issue = (state_r == dsc_pkg::ST_SCAN) && (iss_r < wcount_r);

  // A word is stored only when its length is legal and there is room.
  always_comb begin
    mem_we = in_xfer && (in_chan.data.op == dsc_pkg::OP_ADD_WORD) &&
             (in_chan.data.word_length >= dsc_pkg::LEN_W'(1)) &&
             (in_chan.data.word_length <= dsc_pkg::LEN_W'(dsc_pkg::MAX_WORD_LEN)) &&
             (wcount_r != dsc_pkg::WC_W'(dsc_pkg::DICT_DEPTH));
    mem_wdata.word = in_chan.data.word_symbols;
    mem_wdata.len  = in_chan.data.word_length;
  end

  dsc_dict_mem u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (wcount_r[dsc_pkg::ADDR_W-1:0]),
    .wdata   (mem_wdata),
    .re      (issue),
    .raddr   (iss_r[dsc_pkg::ADDR_W-1:0]),
    .rdata_r (mem_rdata)
  );

  assign ctx.hist = hist_r;
  assign ctx.ways = ways_r;
  assign ctx.sip  = sip_r;

  dsc_match_unit u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (rd_valid_r),
    .entry    (mem_rdata),
    .ctx      (ctx),
    .addend_r (addend),
    .valid_r  (addend_valid)
  );

  // The total for a finished pattern adds either its way count or its
  // exists bit, depending on the mode.
  assign possible  = (acc_r != '0);
  assign total_sum = dsc_pkg::sat_add(total_r,
                                      mode_r ? acc_r : dsc_pkg::COUNT_BITS'(possible));

  always_comb begin
    state_nxt     = state_r;
    wcount_nxt    = wcount_r;
    iss_nxt       = iss_r;
    ovf_nxt       = ovf_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    hist_nxt      = hist_r;
    ways_nxt      = ways_r;
    sip_nxt       = sip_r;
    last_nxt      = last_r;
    rd_valid_nxt  = issue;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      dsc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_chan.data.op)
            dsc_pkg::OP_ADD_WORD: begin
              if (in_chan.data.word_length >= dsc_pkg::LEN_W'(1) &&
                  in_chan.data.word_length <= dsc_pkg::LEN_W'(dsc_pkg::MAX_WORD_LEN)) begin
                if (mem_we) begin
                  wcount_nxt = wcount_r + dsc_pkg::WC_W'(1);
                end else begin
                  ovf_nxt = 1'b1;
                end
              end
            end
            dsc_pkg::OP_SYMBOL: begin
              // Shift the new symbol in and start a scan of the dictionary.
              for (int k = dsc_pkg::MAX_WORD_LEN - 1; k > 0; k--) begin
                hist_nxt[k] = hist_r[k-1];
              end
              hist_nxt[0] = in_chan.data.symbol;
              if (sip_r < dsc_pkg::SIP_W'(dsc_pkg::MAX_WORD_LEN)) begin
                sip_nxt = sip_r + dsc_pkg::SIP_W'(1);
              end
              last_nxt  = in_chan.data.last;
              acc_nxt   = '0;
              iss_nxt   = '0;
              state_nxt = dsc_pkg::ST_SCAN;
            end
            dsc_pkg::OP_CLEAR: begin
              wcount_nxt = '0;
              total_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      dsc_pkg::ST_SCAN: begin
        if (issue) begin
          iss_nxt = iss_r + dsc_pkg::WC_W'(1);
        end
        if (addend_valid) begin
          acc_nxt = dsc_pkg::sat_add(acc_r, addend);
        end
        // The scan is over once nothing is left to issue or in flight.
        if (!issue && !rd_valid_r && !addend_valid) begin
          state_nxt = dsc_pkg::ST_FINISH;
        end
      end
      dsc_pkg::ST_FINISH: begin
        if (!last_r) begin
          for (int k = dsc_pkg::MAX_WORD_LEN - 1; k > 0; k--) begin
            ways_nxt[k] = ways_r[k-1];
          end
          ways_nxt[0] = acc_r;
          state_nxt   = dsc_pkg::ST_IDLE;
        end else if (!out_valid_r || out_chan.ready) begin
          // The result waits here until the output register is free.
          total_nxt                        = total_sum;
          out_valid_nxt                    = 1'b1;
          out_data_nxt.pattern_ways        = dsc_pkg::FIELD_W'(acc_r);
          out_data_nxt.pattern_possible    = possible;
          out_data_nxt.running_total       = dsc_pkg::FIELD_W'(total_sum);
          out_data_nxt.dictionary_overflow = ovf_r;
          hist_nxt                         = '0;
          ways_nxt                         = '0;
          ways_nxt[0]                      = dsc_pkg::COUNT_BITS'(1);
          sip_nxt                          = '0;
          state_nxt                        = dsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dsc_pkg::ST_IDLE;
      wcount_r    <= '0;
      iss_r       <= '0;
      ovf_r       <= 1'b0;
      mode_r      <= 1'b0;
      total_r     <= '0;
      hist_r      <= '0;
      ways_r      <= dsc_pkg::ways_hist_t'(1);
      sip_r       <= '0;
      last_r      <= 1'b0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wcount_r    <= wcount_nxt;
      iss_r       <= iss_nxt;
      ovf_r       <= ovf_nxt;
      total_r     <= total_nxt;
      hist_r      <= hist_nxt;
      ways_r      <= ways_nxt;
      sip_r       <= sip_nxt;
      last_r      <= last_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### src/dsc_checker.sv
// ============================================================================
// Dictionary segmentation counter checker
// Port-level assertions on the result channel and the busy behavior.
// ============================================================================
module dsc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [dsc_pkg::OP_W-1:0] in_op,
  input logic                     out_valid,
  input logic                     out_ready,
  input dsc_pkg::out_item_t       out_data
);

  logic seen_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_ovf_r <= 1'b0;
    end else if (out_valid && out_ready && out_data.dictionary_overflow) begin
      seen_ovf_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == dsc_pkg::OP_SYMBOL)
    |=> !in_ready)
    else $error("input taken during a dictionary scan");

  a_possible_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pattern_possible == (out_data.pattern_ways != '0))
    else $error("exists bit disagrees with way count");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_ovf_r |-> out_data.dictionary_overflow)
    else $error("overflow flag cleared without reset");

endmodule

bind dictionary_segmentation_counter dsc_checker u_dsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_op     (in_chan.data.op),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

### sim/tb_dictionary_segmentation_counter.sv
`timescale 1ns / 100ps
// ============================================================================
// Dictionary segmentation counter testbench
// Drives word loads, clears and pattern symbols into the block and checks
// every finished pattern report against a cycle-free predictor of the
// split-count recurrence. A short directed table comes first, followed by
// random phases, a saturation phase and a dictionary overflow phase, under
// random idling on both channels and two deliberate pressure episodes.
// ============================================================================
module tb_dictionary_segmentation_counter;
  import dsc_pkg::*;

  localparam int CLK_PERIOD = 10;
  // The longest symbol scan covers a full dictionary; leave some margin on top.
  localparam int SETTLE_CYCLES = DICT_DEPTH + 16;
  // A correct run stays well inside this watchdog limit.
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int LONG_HOLD = 300;
  localparam int ITEMS_BEFORE_SPECIAL = 560;
  localparam int ITEM_TARGET = 1170;
  // Op code 3 has no meaning in the block and must be ignored.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        lit;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dsc_in_if  in_if ();
  dsc_out_if out_if ();

  dictionary_segmentation_counter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_if),
    .out_chan  (out_if)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the dictionary, the sliding window of
  // the last MAX_WORD_LEN symbols and prefix counts, the total and the mode.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] dict_word [DICT_DEPTH];
  logic [LEN_W-1:0]  dict_len  [DICT_DEPTH];
  int                dict_size;
  logic [SYM_W-1:0]  sym_window  [MAX_WORD_LEN];
  count_t            ways_window [MAX_WORD_LEN];
  int                pattern_depth;
  count_t            total_q;
  logic              overflow_seen;
  logic              mode_q;

  // Reports the predictor has promised, oldest first.
  out_item_t split_reports_due [$];

  int  failures = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  feed_gaps = 1'b1;
  bit  drain_gaps = 1'b1;
  bit  hold_off_req = 1'b0;

  logic [SYM_W-1:0] alphabet [3];
  int               alpha_n = 2;

  function automatic count_t add_clamped(input count_t a, input count_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? {COUNT_BITS{1'b1}} : s[COUNT_BITS-1:0];
  endfunction

  // The empty prefix has exactly one split; everything older is zero.
  task automatic restart_pattern();
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      sym_window[k]  = '0;
      ways_window[k] = '0;
    end
    ways_window[0] = 1;
    pattern_depth  = 0;
  endtask

  // Advances the predictor by one accepted transfer. A report is produced
  // only for the final symbol of a pattern.
  task automatic predict_split(input in_item_t it, output bit produced,
                               output out_item_t res);
    count_t            ways;
    logic [WORD_W-1:0] w;
    bit                hit;
    int                n;
    produced = 1'b0;
    res      = '0;
    case (it.op)
      OP_ADD_WORD: begin
        if (it.word_length >= 1 && it.word_length <= MAX_WORD_LEN) begin
          if (dict_size >= DICT_DEPTH) begin
            overflow_seen = 1'b1;
          end else begin
            // Bytes beyond the word length do not belong to the word.
            w = it.word_symbols;
            for (int b = 0; b < MAX_WORD_LEN; b++) begin
              if (b >= it.word_length) w[8*b +: 8] = '0;
            end
            dict_word[dict_size] = w;
            dict_len[dict_size]  = it.word_length;
            dict_size++;
          end
        end
      end
      OP_CLEAR: begin
        // The overflow flag and a pattern in progress survive a clear.
        dict_size = 0;
        total_q   = '0;
      end
      OP_SYMBOL: begin
        for (int k = MAX_WORD_LEN - 1; k > 0; k--) sym_window[k] = sym_window[k-1];
        sym_window[0] = it.symbol;
        if (pattern_depth < MAX_WORD_LEN) pattern_depth++;
        ways = '0;
        for (int e = 0; e < dict_size; e++) begin
          n = dict_len[e];
          if (n <= pattern_depth) begin
            hit = 1'b1;
            for (int j = 0; j < n; j++) begin
              if (dict_word[e][8*j +: 8] != sym_window[n-1-j]) hit = 1'b0;
            end
            if (hit) ways = add_clamped(ways, ways_window[n-1]);
          end
        end
        for (int k = MAX_WORD_LEN - 1; k > 0; k--) ways_window[k] = ways_window[k-1];
        ways_window[0] = ways;
        if (it.last) begin
          total_q = add_clamped(total_q, mode_q ? ways : count_t'(ways != 0));
          res.pattern_ways        = ways;
          res.pattern_possible    = (ways != 0);
          res.running_total       = total_q;
          res.dictionary_overflow = overflow_seen;
          produced = 1'b1;
          restart_pattern();
        end
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Item builders. Fields an op does not use are filled at random so that
  // every input bit toggles without changing the expected behavior.
  // --------------------------------------------------------------------------
  function automatic logic [WORD_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] w,
                                         logic [LEN_W-1:0] len, logic [SYM_W-1:0] s,
                                         logic l);
    in_item_t it;
    it.op           = op;
    it.word_symbols = w;
    it.word_length  = len;
    it.symbol       = s;
    it.last         = l;
    return it;
  endfunction

  function automatic dir_row_t row(logic [OP_W-1:0] op, logic [WORD_W-1:0] w,
                                   logic [LEN_W-1:0] len, logic [SYM_W-1:0] s,
                                   logic l, bit lit, count_t ways, logic poss,
                                   count_t total, logic ovf);
    dir_row_t r;
    r.item = make_item(op, w, len, s, l);
    r.lit  = lit;
    r.want.pattern_ways        = ways;
    r.want.pattern_possible    = poss;
    r.want.running_total       = total;
    r.want.dictionary_overflow = ovf;
    return r;
  endfunction

  // A small alphabet makes words match each other and the patterns often.
  function automatic logic [SYM_W-1:0] pick_sym();
    return alphabet[$urandom_range(0, alpha_n - 1)];
  endfunction

  task automatic choose_alphabet(input int size);
    alpha_n = size;
    for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom);
  endtask

  // Mostly short words, now and then up to the longest allowed length.
  function automatic in_item_t word_item();
    logic [WORD_W-1:0] w;
    int                len;
    w   = rand64();
    len = ($urandom_range(0, 4) == 0) ? $urandom_range(5, MAX_WORD_LEN)
                                      : $urandom_range(1, 4);
    for (int j = 0; j < len; j++) w[8*j +: 8] = pick_sym();
    return make_item(OP_ADD_WORD, w, LEN_W'(len), 8'($urandom), 1'($urandom));
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Each item waits a random gap, is held until the transfer, and
  // only then advances the predictor. Valid stays high from one item to the
  // next when there is no gap, so it never gets two assignments in a step.
  // --------------------------------------------------------------------------
  task automatic send_item(input in_item_t it, input bit lit, input out_item_t want);
    int        gap;
    bit        produced;
    out_item_t res;
    gap = feed_gaps ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    items_sent++;
    predict_split(it, produced, res);
    // Directed rows with a hand-written answer take that answer instead.
    if (produced) split_reports_due.insert(split_reports_due.size(), lit ? want : res);
  endtask

  // Stop offering and wait until every promised report has been received.
  task automatic drain_all();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (split_reports_due.size() != 0);
  endtask

  // The mode register is only written with the block idle. A word add or a
  // symbol without last gives no report, so the block may still be busy
  // after the queue empties; wait out the longest scan before writing.
  task automatic set_mode(input logic m);
    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mode_q     = m;
  endtask

  // Items the block must ignore or that disturb a pattern in progress.
  task automatic send_noise();
    logic [LEN_W-1:0] bad_len;
    bad_len = $urandom_range(0, 1) ? LEN_W'(0) : LEN_W'($urandom_range(9, 15));
    case ($urandom_range(0, 5))
      0, 1: send_item(make_item(OP_ADD_WORD, rand64(), bad_len, 8'($urandom),
                                1'($urandom)), 1'b0, '0);
      2: send_item(make_item(OP_UNUSED, rand64(), 4'($urandom), 8'($urandom),
                             1'($urandom)), 1'b0, '0);
      3, 4: send_item(word_item(), 1'b0, '0);
      default: send_item(make_item(OP_CLEAR, rand64(), 4'($urandom), 8'($urandom),
                                   1'($urandom)), 1'b0, '0);
    endcase
  endtask

  // A pattern is usually a string of dictionary words, sometimes with one
  // symbol spoiled, otherwise a random string over the phase alphabet with
  // an occasional symbol from the full range.
  task automatic send_pattern();
    logic [SYM_W-1:0] syms [$];
    int               e;
    int               n;
    if (dict_size > 0 && $urandom_range(0, 3) != 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        e = $urandom_range(0, dict_size - 1);
        for (int j = 0; j < dict_len[e]; j++) syms.insert(syms.size(), dict_word[e][8*j +: 8]);
      end
      if ($urandom_range(0, 4) == 0) syms[$urandom_range(0, syms.size() - 1)] = pick_sym();
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        syms.insert(syms.size(), ($urandom_range(0, 7) == 0) ? 8'($urandom) : pick_sym());
      end
    end
    for (int i = 0; i < syms.size(); i++) begin
      if ($urandom_range(0, 11) == 0) send_noise();
      send_item(make_item(OP_SYMBOL, rand64(), 4'($urandom), syms[i],
                          i == syms.size() - 1), 1'b0, '0);
    end
  endtask

  // One random phase: a mode setting, fresh idling choices, a few words and
  // a batch of patterns. The dictionary is kept small so scans stay short.
  task automatic run_phase(input logic m, input bit with_hold, input bit with_pause);
    int n_words;
    int n_pats;
    set_mode(m);
    choose_alphabet($urandom_range(2, 3));
    feed_gaps  = ($urandom_range(0, 2) != 0);
    drain_gaps = ($urandom_range(0, 3) != 0);
    if (dict_size > 24 || $urandom_range(0, 1) == 1) begin
      send_item(make_item(OP_CLEAR, rand64(), 4'($urandom), 8'($urandom),
                          1'($urandom)), 1'b0, '0);
    end
    n_words = $urandom_range(1, 6);
    repeat (n_words) send_item(word_item(), 1'b0, '0);
    n_pats = $urandom_range(6, 12);
    for (int p = 0; p < n_pats; p++) begin
      // The receiver stops for a long stretch while the sender keeps going
      // back to back, so the block backs up into its input.
      if (with_hold && p == 1) begin
        feed_gaps    = 1'b0;
        hold_off_req = 1'b1;
      end
      // The sender stops mid-phase until every report is back.
      if (with_pause && p == n_pats / 2) drain_all();
      send_pattern();
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver and checker. Ready follows a per-transfer random stall, or a
  // long hold when the sender asks for one. Each transfer is compared field
  // by field with the oldest promised report.
  // --------------------------------------------------------------------------
  initial begin
    int        stall;
    out_item_t exp_r;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (split_reports_due.size() == 0) begin
          $display("%0t unexpected report: expected none, actual ways %0d total %0d",
                   $time, out_if.data.pattern_ways, out_if.data.running_total);
          failures++;
        end else begin
          exp_r = split_reports_due.pop_front();
          if (out_if.data.pattern_ways !== exp_r.pattern_ways) begin
            $display("%0t pattern_ways mismatch: expected %0d, actual %0d",
                     $time, exp_r.pattern_ways, out_if.data.pattern_ways);
            failures++;
          end
          if (out_if.data.pattern_possible !== exp_r.pattern_possible) begin
            $display("%0t pattern_possible mismatch: expected %0b, actual %0b",
                     $time, exp_r.pattern_possible, out_if.data.pattern_possible);
            failures++;
          end
          if (out_if.data.running_total !== exp_r.running_total) begin
            $display("%0t running_total mismatch: expected %0d, actual %0d",
                     $time, exp_r.running_total, out_if.data.running_total);
            failures++;
          end
          if (out_if.data.dictionary_overflow !== exp_r.dictionary_overflow) begin
            $display("%0t dictionary_overflow mismatch: expected %0b, actual %0b",
                     $time, exp_r.dictionary_overflow, out_if.data.dictionary_overflow);
            failures++;
          end
        end
        stall = drain_gaps ? $urandom_range(0, 14) : 0;
      end
      if (hold_off_req) begin
        stall        = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[dictionary_segmentation_counter] ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t         directed [$];
    logic [SYM_W-1:0] sat_sym;
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_wdata      <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.data     <= '0;
    dict_size      = 0;
    total_q        = '0;
    overflow_seen  = 1'b0;
    mode_q         = 1'b0;
    restart_pattern();
    choose_alphabet(2);

    // Directed rows, all in the reset mode that adds one per splittable
    // pattern. Rows with a typed answer are simple enough to read by eye.
    directed = '{
      // Empty dictionary right after reset: no split, nothing added.
      row(OP_SYMBOL,   '1,                     4'd15, 8'h00, 1'b1, 1, 0, 0, 0, 0),
      // Word lengths out of range and the unused op are all ignored.
      row(OP_ADD_WORD, '1,                     4'd0,  8'hFF, 1'b1, 0, 0, 0, 0, 0),
      row(OP_ADD_WORD, 64'h0102_0304_0506_0708, 4'd9, 8'h00, 1'b0, 0, 0, 0, 0, 0),
      row(OP_UNUSED,   '1,                     4'd1,  8'hFF, 1'b1, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd1,  8'hFF, 1'b1, 1, 0, 0, 0, 0),
      // Junk above the word length must not take part in matching.
      row(OP_ADD_WORD, 64'hFFFF_FFFF_FFFF_FF61, 4'd1, 8'h00, 1'b0, 0, 0, 0, 0, 0),
      row(OP_ADD_WORD, 64'h5555_5555_5555_6261, 4'd2, 8'h00, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'h61, 1'b1, 1, 1, 1, 1, 0),
      row(OP_SYMBOL,   '1,                     4'd15, 8'h61, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'h62, 1'b1, 1, 1, 1, 2, 0),
      // Longest word with every symbol bit set, matched by a full window.
      row(OP_ADD_WORD, '1,                     4'd8,  8'h00, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'hFF, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'hFF, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'hFF, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'hFF, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'hFF, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'hFF, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'hFF, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '1,                     4'd0,  8'hFF, 1'b1, 1, 1, 1, 3, 0),
      row(OP_ADD_WORD, 64'h61,                 4'd15, 8'h00, 1'b0, 0, 0, 0, 0, 0),
      // The same word stored twice is counted twice.
      row(OP_ADD_WORD, 64'hDEAD_BEEF_0000_0061, 4'd1, 8'h00, 1'b0, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'h61, 1'b1, 1, 2, 1, 4, 0),
      // A clear in the middle of a pattern empties the dictionary and total.
      row(OP_SYMBOL,   '0,                     4'd0,  8'h61, 1'b0, 0, 0, 0, 0, 0),
      row(OP_CLEAR,    '1,                     4'd15, 8'hFF, 1'b1, 0, 0, 0, 0, 0),
      row(OP_SYMBOL,   '0,                     4'd0,  8'h62, 1'b1, 1, 0, 0, 0, 0)
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i].item, directed[i].lit, directed[i].want);

    // Random phases; the third one carries the long receiver hold and the
    // fourth the sender pause.
    for (int p = 0; items_sent < ITEMS_BEFORE_SPECIAL; p++) begin
      run_phase((p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom), p == 2, p == 3);
    end

    // Saturation: sixteen copies of one single-symbol word multiply the
    // count by sixteen per symbol, so a long run of that symbol overflows
    // both the count and the total in the way-count mode.
    set_mode(1'b1);
    feed_gaps  = 1'b1;
    drain_gaps = 1'b1;
    sat_sym    = 8'($urandom);
    send_item(make_item(OP_CLEAR, rand64(), 4'($urandom), 8'($urandom), 1'($urandom)),
              1'b0, '0);
    repeat (16) begin
      send_item(make_item(OP_ADD_WORD, {56'(rand64()), sat_sym}, 4'd1, 8'($urandom),
                          1'($urandom)), 1'b0, '0);
    end
    for (int i = 0; i < 20; i++) begin
      send_item(make_item(OP_SYMBOL, rand64(), 4'($urandom), sat_sym, i == 19), 1'b0, '0);
    end
    for (int i = 0; i < 2; i++) begin
      send_item(make_item(OP_SYMBOL, rand64(), 4'($urandom), sat_sym, i == 1), 1'b0, '0);
    end

    // Dictionary overflow: fill every entry, push a few more words that are
    // dropped, and run patterns against the full dictionary. The flag is
    // sticky from here to the end of the run.
    set_mode(1'($urandom));
    choose_alphabet(2);
    feed_gaps  = ($urandom_range(0, 1) == 1);
    drain_gaps = ($urandom_range(0, 1) == 1);
    send_item(make_item(OP_CLEAR, rand64(), 4'($urandom), 8'($urandom), 1'($urandom)),
              1'b0, '0);
    repeat (DICT_DEPTH + 3) send_item(word_item(), 1'b0, '0);
    repeat (4) send_pattern();

    do begin
      run_phase(1'($urandom), 1'b0, 1'b0);
    end while (items_sent < ITEM_TARGET);

    // Let the last reports arrive and give a stray one time to show up.
    drain_all();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[dictionary_segmentation_counter] OK");
    end else begin
      $display("[dictionary_segmentation_counter] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/dsc_pkg.sv
src/dsc_in_if.sv
src/dsc_out_if.sv
src/dsc_dict_mem.sv
src/dsc_match_unit.sv
src/dictionary_segmentation_counter.sv
src/dsc_checker.sv
sim/tb_dictionary_segmentation_counter.sv
